// ===== design/trx_pkg.sv =====
// Package for the ray/triangle intersection unit.
// Holds the fixed field widths, the divider depth and the register index codes.
// No dependencies.
package trx_pkg;

	// fixed field widths
	localparam int DIST_W     = 20;
	localparam int TEX_W      = 16;
	localparam int TEXREG_W   = 32;
	localparam int CFG_DATA_W = 63;
	localparam int CFG_IDX_W  = 4;

	// quotient bits produced by each divider, one per stage
	localparam int QBITS = 20;

	// configuration register index codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTEX_A   = 4'd0,
		REG_VERTEX_B   = 4'd1,
		REG_VERTEX_C   = 4'd2,
		REG_TEXCOORD_A = 4'd3,
		REG_TEXCOORD_B = 4'd4,
		REG_TEXCOORD_C = 4'd5,
		REG_MIN_DIST   = 4'd6,
		REG_MAX_DIST   = 4'd7
	} cfg_reg_t;

endpackage

// ===== design/trx_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Generic widths; used by the intersection unit top level. No package needed.
module trx_div_pipe #(
	parameter int XW = 90,
	parameter int QB = 20
) (
	input  logic          clk,
	input  logic          en,
	input  logic [XW-1:0] num,
	input  logic [XW-1:0] den,
	output logic [QB-1:0] quo
);

	logic [XW-1:0] rem_q [QB-1];
	logic [XW-1:0] den_q [QB-1];
	logic [QB-1:0] quo_q [QB];

	for (genvar j = 0; j < QB; j++) begin : g_step
		logic [XW-1:0] r_in;
		logic [XW-1:0] d_in;
		logic [XW-1:0] d_sh;
		logic [QB-1:0] q_in;
		logic          take;

		if (j == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_q[j-1];
			assign d_in = den_q[j-1];
			assign q_in = quo_q[j-1];
		end

		// trial subtract of the divisor aligned to this bit
		assign d_sh = d_in << (QB - 1 - j);
		assign take = (r_in >= d_sh);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[j] <= {q_in[QB-2:0], take};
			end
		end

		if (j < QB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j] <= take ? (r_in - d_sh) : r_in;
					den_q[j] <= d_in;
				end
			end
		end
	end

	assign quo = quo_q[QB-1];

endmodule

// ===== design/triangle_ray_intersect_unit.sv =====
// Ray/triangle intersection unit (Moller-Trumbore), signed fixed point.
// Depends on trx_pkg and trx_div_pipe.
//
// channel | signals                                   | direction
// cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in (write)
// in      | in_valid in_ready ray_origin_* ray_dir_*  | in
// out     | out_valid out_ready hit_* tex_u tex_v     | out
//
// One ray enters per cycle unless the output is stalled.
// The three 20-stage restoring dividers (distance and u/v) sit between stages 6 and 7.
// Reset clears the valid chain and loads the register defaults.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
module triangle_ray_intersect_unit
	import trx_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 10,
	parameter int COORD_WIDTH     = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_x,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_y,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_z,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_x,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_y,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit_flag,
	output logic [DIST_W-1:0]             hit_distance,
	output logic signed [COORD_WIDTH-1:0] hit_pos_x,
	output logic signed [COORD_WIDTH-1:0] hit_pos_y,
	output logic signed [COORD_WIDTH-1:0] hit_pos_z,
	output logic [TEX_W-1:0]              tex_u,
	output logic [TEX_W-1:0]              tex_v
);

	localparam int CW  = COORD_WIDTH;
	localparam int F   = COORD_FRAC_BITS;
	localparam int EW  = CW + 1;          // edges, origin offset
	localparam int SW  = 2 * EW + 1;      // cross products
	localparam int PW  = SW + EW;         // dot product terms
	localparam int DTW = PW + 2;          // dot product sums
	localparam int XW  = DTW + QBITS + 1; // divider datapath
	localparam int TPW = TEX_W + DTW;     // texture weight products
	localparam int PRW = CW + DIST_W + 1; // direction times distance
	localparam int PSW = PRW + 1;         // hit point before saturation

	localparam logic signed [PSW-1:0] POS_MAX = {{(PSW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [PSW-1:0] POS_MIN = {{(PSW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	// configuration registers
	logic [CFG_DATA_W-1:0] vertex_a_q, vertex_b_q, vertex_c_q;
	logic [TEXREG_W-1:0]   texcoord_a_q, texcoord_b_q, texcoord_c_q;
	logic [DIST_W-1:0]     min_distance_q, max_distance_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_a_q     <= '0;
			vertex_b_q     <= '0;
			vertex_c_q     <= '0;
			texcoord_a_q   <= '0;
			texcoord_b_q   <= '0;
			texcoord_c_q   <= '0;
			min_distance_q <= DIST_W'(1);
			max_distance_q <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VERTEX_A:   vertex_a_q     <= cfg_data;
				REG_VERTEX_B:   vertex_b_q     <= cfg_data;
				REG_VERTEX_C:   vertex_c_q     <= cfg_data;
				REG_TEXCOORD_A: texcoord_a_q   <= cfg_data[TEXREG_W-1:0];
				REG_TEXCOORD_B: texcoord_b_q   <= cfg_data[TEXREG_W-1:0];
				REG_TEXCOORD_C: texcoord_c_q   <= cfg_data[TEXREG_W-1:0];
				REG_MIN_DIST:   min_distance_q <= cfg_data[DIST_W-1:0];
				REG_MAX_DIST:   max_distance_q <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// vertex unpack; slices past the register top read as zero
	logic [3*CW-1:0]       vxa, vxb, vxc;
	logic signed [CW-1:0]  va [3];
	logic signed [EW-1:0]  e1 [3];
	logic signed [EW-1:0]  e2 [3];
	logic signed [CW-1:0]  org_in [3];
	logic signed [CW-1:0]  dir_in [3];

	assign vxa = (3*CW)'(vertex_a_q);
	assign vxb = (3*CW)'(vertex_b_q);
	assign vxc = (3*CW)'(vertex_c_q);
	assign org_in[0] = ray_origin_x;
	assign org_in[1] = ray_origin_y;
	assign org_in[2] = ray_origin_z;
	assign dir_in[0] = ray_dir_x;
	assign dir_in[1] = ray_dir_y;
	assign dir_in[2] = ray_dir_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = signed'(vxa[i*CW +: CW]);
			e1[i] = EW'(signed'(vxb[i*CW +: CW])) - EW'(va[i]);
			e2[i] = EW'(signed'(vxc[i*CW +: CW])) - EW'(va[i]);
		end
	end

	function automatic logic signed [SW-1:0] xterm(
		input logic signed [EW-1:0] a1, input logic signed [EW-1:0] b2,
		input logic signed [EW-1:0] a2, input logic signed [EW-1:0] b1);
		logic signed [SW-1:0] p;
		logic signed [SW-1:0] q;
		p = SW'(a1) * SW'(b2);
		q = SW'(a2) * SW'(b1);
		return p - q;
	endfunction

	function automatic logic signed [PW-1:0] pmul(
		input logic signed [SW-1:0] a, input logic signed [EW-1:0] b);
		return PW'(a) * PW'(b);
	endfunction

	function automatic logic signed [DTW-1:0] sum3(
		input logic signed [PW-1:0] a, input logic signed [PW-1:0] b,
		input logic signed [PW-1:0] c);
		return DTW'(a) + DTW'(b) + DTW'(c);
	endfunction

	// pipeline advance: everything moves unless the output item is held
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_d [QBITS];

	assign adv      = !v_s8 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			for (int k = 0; k < QBITS; k++) v_d[k] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_d[0] <= v_s6;
			for (int k = 1; k < QBITS; k++) v_d[k] <= v_d[k-1];
			v_s7 <= v_d[QBITS-1];
			v_s8 <= v_s7;
		end
	end

	// stage 1: capture ray, origin offset from vertex A
	logic signed [CW-1:0] org_s1 [3], dir_s1 [3];
	logic signed [EW-1:0] d_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				org_s1[i] <= org_in[i];
				dir_s1[i] <= dir_in[i];
				d_s1[i]   <= EW'(org_in[i]) - EW'(va[i]);
			end
		end
	end

	// stage 2: s1 = dir x e2, s2 = d x e1
	logic signed [CW-1:0] org_s2 [3], dir_s2 [3];
	logic signed [EW-1:0] d_s2 [3];
	logic signed [SW-1:0] sa_s2 [3], sb_s2 [3];
	logic signed [EW-1:0] de [3];

	always_comb begin
		for (int i = 0; i < 3; i++) de[i] = EW'(dir_s1[i]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			org_s2 <= org_s1;
			dir_s2 <= dir_s1;
			d_s2   <= d_s1;
			sa_s2[0] <= xterm(de[1], e2[2], de[2], e2[1]);
			sa_s2[1] <= xterm(de[2], e2[0], de[0], e2[2]);
			sa_s2[2] <= xterm(de[0], e2[1], de[1], e2[0]);
			sb_s2[0] <= xterm(d_s1[1], e1[2], d_s1[2], e1[1]);
			sb_s2[1] <= xterm(d_s1[2], e1[0], d_s1[0], e1[2]);
			sb_s2[2] <= xterm(d_s1[0], e1[1], d_s1[1], e1[0]);
		end
	end

	// stage 3: dot product terms
	logic signed [CW-1:0] org_s3 [3], dir_s3 [3];
	logic signed [PW-1:0] det_p_s3 [3], nb_p_s3 [3], ng_p_s3 [3], nt_p_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			org_s3 <= org_s2;
			dir_s3 <= dir_s2;
			for (int i = 0; i < 3; i++) begin
				det_p_s3[i] <= pmul(sa_s2[i], e1[i]);
				nb_p_s3[i]  <= pmul(sa_s2[i], d_s2[i]);
				ng_p_s3[i]  <= pmul(sb_s2[i], EW'(dir_s2[i]));
				nt_p_s3[i]  <= pmul(sb_s2[i], e2[i]);
			end
		end
	end

	// stage 4: sums, sign folded into the determinant
	logic signed [CW-1:0]  org_s4 [3], dir_s4 [3];
	logic signed [DTW-1:0] det_w, nb_w, ng_w, nt_w;
	logic signed [DTW-1:0] det_s4, nb_s4, ng_s4, nt_s4;
	logic                  neg;

	assign det_w = sum3(det_p_s3[0], det_p_s3[1], det_p_s3[2]);
	assign nb_w  = sum3(nb_p_s3[0], nb_p_s3[1], nb_p_s3[2]);
	assign ng_w  = sum3(ng_p_s3[0], ng_p_s3[1], ng_p_s3[2]);
	assign nt_w  = sum3(nt_p_s3[0], nt_p_s3[1], nt_p_s3[2]);
	assign neg   = det_w[DTW-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			org_s4 <= org_s3;
			dir_s4 <= dir_s3;
			det_s4 <= neg ? -det_w : det_w;
			nb_s4  <= neg ? -nb_w  : nb_w;
			ng_s4  <= neg ? -ng_w  : ng_w;
			nt_s4  <= neg ? -nt_w  : nt_w;
		end
	end

	// stage 5: inside tests, distance overflow, texture weight products
	logic signed [CW-1:0]  org_s5 [3], dir_s5 [3];
	logic signed [DTW:0]   nbng;
	logic signed [DTW-1:0] wa;
	logic [XW-1:0]         n_x, dl_x;
	logic                  outside, ovf;
	logic [DTW-1:0]        wgt [3];
	logic                  miss_s5;
	logic [XW-1:0]         num_t_s5;
	logic [DTW-1:0]        det_s5;
	logic [TPW-1:0]        tu_p_s5 [3], tv_p_s5 [3];
	logic [TEXREG_W-1:0]   tc [3];

	assign nbng = (DTW+1)'(nb_s4) + (DTW+1)'(ng_s4);
	assign wa   = det_s4 - nb_s4 - ng_s4;
	assign outside = (det_s4 == '0) || (nb_s4 <= 0) || (nb_s4 >= det_s4) || (ng_s4 <= 0)
		|| (nbng >= (DTW+1)'(det_s4)) || (nt_s4 < 0);
	assign n_x  = XW'($unsigned(nt_s4)) << F;
	assign dl_x = XW'($unsigned(det_s4)) << QBITS;
	assign ovf  = (n_x >= dl_x);
	assign wgt[0] = $unsigned(wa);
	assign wgt[1] = $unsigned(nb_s4);
	assign wgt[2] = $unsigned(ng_s4);
	assign tc[0] = texcoord_a_q;
	assign tc[1] = texcoord_b_q;
	assign tc[2] = texcoord_c_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			org_s5   <= org_s4;
			dir_s5   <= dir_s4;
			miss_s5  <= outside || ovf;
			num_t_s5 <= ovf ? '0 : n_x;
			det_s5   <= $unsigned(det_s4);
			for (int i = 0; i < 3; i++) begin
				tu_p_s5[i] <= TPW'(tc[i][TEX_W-1:0]) * TPW'(wgt[i]);
				tv_p_s5[i] <= TPW'(tc[i][TEXREG_W-1:TEX_W]) * TPW'(wgt[i]);
			end
		end
	end

	// stage 6: texture numerators, divider operands
	logic signed [CW-1:0] org_s6 [3], dir_s6 [3];
	logic                 miss_s6;
	logic [XW-1:0]        num_t_s6, num_u_s6, num_v_s6, den_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			org_s6   <= org_s5;
			dir_s6   <= dir_s5;
			miss_s6  <= miss_s5;
			num_t_s6 <= num_t_s5;
			den_s6   <= XW'(det_s5);
			num_u_s6 <= XW'(tu_p_s5[0]) + XW'(tu_p_s5[1]) + XW'(tu_p_s5[2]);
			num_v_s6 <= XW'(tv_p_s5[0]) + XW'(tv_p_s5[1]) + XW'(tv_p_s5[2]);
		end
	end

	// dividers: distance and both texture coordinates
	logic [QBITS-1:0] q_t, q_u, q_v;

	trx_div_pipe #(.XW(XW), .QB(QBITS)) u_div_t (
		.clk(clk), .en(adv), .num(num_t_s6), .den(den_s6), .quo(q_t)
	);
	trx_div_pipe #(.XW(XW), .QB(QBITS)) u_div_u (
		.clk(clk), .en(adv), .num(num_u_s6), .den(den_s6), .quo(q_u)
	);
	trx_div_pipe #(.XW(XW), .QB(QBITS)) u_div_v (
		.clk(clk), .en(adv), .num(num_v_s6), .den(den_s6), .quo(q_v)
	);

	// side data delayed alongside the dividers
	logic                 miss_d [QBITS];
	logic signed [CW-1:0] org_d [QBITS][3];
	logic signed [CW-1:0] dir_d [QBITS][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_d[0] <= miss_s6;
			org_d[0]  <= org_s6;
			dir_d[0]  <= dir_s6;
			for (int k = 1; k < QBITS; k++) begin
				miss_d[k] <= miss_d[k-1];
				org_d[k]  <= org_d[k-1];
				dir_d[k]  <= dir_d[k-1];
			end
		end
	end

	// stage 7: distance range check, direction times distance
	logic [DIST_W-1:0]    tq;
	logic                 hit_s7;
	logic [DIST_W-1:0]    tq_s7;
	logic [TEX_W-1:0]     tu_s7, tv_s7;
	logic signed [CW-1:0] org_s7 [3];
	logic signed [PRW-1:0] prod_s7 [3];

	assign tq = q_t[DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s7 <= !miss_d[QBITS-1] && (tq >= min_distance_q) && (tq <= max_distance_q);
			tq_s7  <= tq;
			tu_s7  <= q_u[TEX_W-1:0];
			tv_s7  <= q_v[TEX_W-1:0];
			org_s7 <= org_d[QBITS-1];
			for (int i = 0; i < 3; i++) begin
				prod_s7[i] <= PRW'(dir_d[QBITS-1][i]) * PRW'(signed'({1'b0, tq}));
			end
		end
	end

	// stage 8: hit point with floor shift and saturation, output register
	logic signed [PSW-1:0] psum [3];
	logic signed [CW-1:0]  pos [3];
	logic signed [CW-1:0]  pos_s8 [3];
	logic                  hit_s8;
	logic [DIST_W-1:0]     dist_s8;
	logic [TEX_W-1:0]      tu_s8, tv_s8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			psum[i] = PSW'(org_s7[i]) + PSW'(prod_s7[i] >>> F);
			if (psum[i] > POS_MAX) begin
				pos[i] = POS_MAX[CW-1:0];
			end else if (psum[i] < POS_MIN) begin
				pos[i] = POS_MIN[CW-1:0];
			end else begin
				pos[i] = psum[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s8  <= hit_s7;
			dist_s8 <= hit_s7 ? tq_s7 : '0;
			tu_s8   <= hit_s7 ? tu_s7 : '0;
			tv_s8   <= hit_s7 ? tv_s7 : '0;
			for (int i = 0; i < 3; i++) pos_s8[i] <= hit_s7 ? pos[i] : '0;
		end
	end

	assign out_valid    = v_s8;
	assign hit_flag     = hit_s8;
	assign hit_distance = dist_s8;
	assign hit_pos_x    = pos_s8[0];
	assign hit_pos_y    = pos_s8[1];
	assign hit_pos_z    = pos_s8[2];
	assign tex_u        = tu_s8;
	assign tex_v        = tv_s8;

	// a miss carries an all-zero item
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_flag |-> hit_distance == '0 && tex_u == '0 && tex_v == '0
			&& hit_pos_x == '0 && hit_pos_y == '0 && hit_pos_z == '0)
		else $error("miss item has nonzero fields");

	// a hit lies within the programmed distance window
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_flag |-> hit_distance >= min_distance_q
			&& hit_distance <= max_distance_q)
		else $error("hit distance outside window");

	// a held output freezes the first stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(v_s1))
		else $error("pipeline moved during stall");

endmodule
